// ===== src/assert_macros.svh =====
// assertion helper macros shared by the slip framer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sfe_pkg.sv =====
// types and constants for the slip frame encoder
// no dependencies; imported by the interfaces and all modules
package sfe_pkg;

  typedef logic [7:0] byte_t;

  // framing and escape codes
  localparam byte_t SLIP_END     = 8'hC0;
  localparam byte_t SLIP_ESC     = 8'hDB;
  localparam byte_t SLIP_ESC_END = 8'hDC;
  localparam byte_t SLIP_ESC_ESC = 8'hDD;

  // an item expands to at most four line bytes
  localparam int MAX_RUN = 4;
  localparam int SLOT_W  = 2;

  typedef logic [SLOT_W-1:0] slot_t;

  // one queued run of line bytes, last_slot is the index of its final byte
  typedef struct packed {
    slot_t               last_slot;
    byte_t [MAX_RUN-1:0] bytes;
  } run_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ===== src/sfe_in_if.sv =====
// input channel: one payload byte with framing flags
// depends on sfe_pkg
interface sfe_in_if;
  import sfe_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_of_packet;
  logic  last_of_packet;
  logic  add_head;
  logic  add_tail;
  logic  empty_packet;

  modport source (
    output valid, data_byte, first_of_packet, last_of_packet,
    output add_head, add_tail, empty_packet,
    input  ready
  );

  modport sink (
    input  valid, data_byte, first_of_packet, last_of_packet,
    input  add_head, add_tail, empty_packet,
    output ready
  );

endinterface

// ===== src/sfe_out_if.sv =====
// output channel: one encoded line byte with end-of-run flag
// depends on sfe_pkg
interface sfe_out_if;
  import sfe_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_run;

  modport source (
    output valid, out_byte, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_of_run,
    output ready
  );

endinterface

// ===== src/sfe_front.sv =====
// front end: accepts items and expands each into a run of line bytes
// depends on sfe_pkg, sfe_in_if, assert_macros.svh
`include "assert_macros.svh"

module sfe_front (
  input  logic             clk,
  input  logic             rst,
  sfe_in_if.sink           in_ch,
  input  sfe_pkg::q_stat_t stat,
  output logic             push,
  output sfe_pkg::run_t    run
);
  import sfe_pkg::*;

  logic accept;
  logic has_head;
  logic has_tail;
  logic has_data;
  logic [SLOT_W:0] pos;

  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // an empty packet counts as both first and last
  assign has_head = in_ch.add_head && (in_ch.first_of_packet || in_ch.empty_packet);
  assign has_tail = in_ch.add_tail && (in_ch.last_of_packet || in_ch.empty_packet);
  assign has_data = !in_ch.empty_packet;

  // lay the bytes out in transmission order
  always_comb begin
    run.bytes = '0;
    pos       = '0;
    if (has_head) begin
      run.bytes[pos[SLOT_W-1:0]] = SLIP_END;
      pos = pos + 1'b1;
    end
    if (has_data) begin
      if (in_ch.data_byte == SLIP_END) begin
        run.bytes[pos[SLOT_W-1:0]] = SLIP_ESC;
        pos = pos + 1'b1;
        run.bytes[pos[SLOT_W-1:0]] = SLIP_ESC_END;
        pos = pos + 1'b1;
      end else if (in_ch.data_byte == SLIP_ESC) begin
        run.bytes[pos[SLOT_W-1:0]] = SLIP_ESC;
        pos = pos + 1'b1;
        run.bytes[pos[SLOT_W-1:0]] = SLIP_ESC_ESC;
        pos = pos + 1'b1;
      end else begin
        run.bytes[pos[SLOT_W-1:0]] = in_ch.data_byte;
        pos = pos + 1'b1;
      end
    end
    if (has_tail) begin
      run.bytes[pos[SLOT_W-1:0]] = SLIP_END;
      pos = pos + 1'b1;
    end
    run.last_slot = SLOT_W'(pos - 1'b1);
  end

  // items that produce no bytes are consumed without queueing
  assign push = accept && (pos != '0);

  `ASSERT_RST(a_empty_no_push, clk, rst, (accept && in_ch.empty_packet && !in_ch.add_head && !in_ch.add_tail) |-> !push, "bare empty packet queued a run")
  `ASSERT_RST(a_push_room, clk, rst, push |-> !stat.full, "run pushed into a full queue")
  `ASSERT_RST(a_data_in_run, clk, rst, (push && has_data && !has_head && !has_tail && in_ch.data_byte != SLIP_END && in_ch.data_byte != SLIP_ESC) |-> (run.last_slot == '0), "plain byte run has wrong length")

endmodule

// ===== src/sfe_queue.sv =====
// short run queue between front and back, flop based
// depends on sfe_pkg, assert_macros.svh
`include "assert_macros.svh"

module sfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfe_pkg::run_t     wr_run,
  input  logic              pop,
  output sfe_pkg::run_t     head,
  output sfe_pkg::q_stat_t  stat
);
  import sfe_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign head           = entries[rd_ptr];
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.not_empty = (count != '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_run;
    end
  end

  // count is unknown before the first reset edge, so reset covers it
  `ASSERT_ALWAYS(a_count_range, clk, rst || (count <= CNT_W'(DEPTH)),
                 "queue count out of range")
  `ASSERT_RST(a_pop_valid, clk, rst, pop |-> stat.not_empty, "pop from an empty queue")
  `ASSERT_RST(a_count_up, clk, rst,
              (push && !pop) |=> (count == CNT_W'($past(count) + 1'b1)),
              "count missed a push")

endmodule

// ===== src/sfe_back.sv =====
// back end: sends the queued runs one byte per cycle through an output register while out_ch is not stalled
// depends on sfe_pkg, sfe_out_if, assert_macros.svh
`include "assert_macros.svh"

module sfe_back (
  input  logic             clk,
  input  logic             rst,
  input  sfe_pkg::run_t    head,
  input  sfe_pkg::q_stat_t stat,
  output logic             pop,
  sfe_out_if.source        out_ch
);
  import sfe_pkg::*;

  slot_t slot;
  logic  out_valid;
  byte_t out_byte;
  logic  out_last;
  logic  load;
  logic  take;
  logic  run_done;

  assign load     = !out_valid || out_ch.ready;
  assign take     = load && stat.not_empty;
  assign run_done = (slot == head.last_slot);
  assign pop      = take && run_done;

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;

  // output valid and position within the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else if (load) begin
      out_valid <= stat.not_empty;
      if (take) begin
        slot <= run_done ? '0 : slot + 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= head.bytes[slot];
      out_last <= run_done;
    end
  end

  `ASSERT_RST(a_pop_resets_slot, clk, rst, pop |=> (slot == '0), "slot not rewound after a run")
  `ASSERT_RST(a_last_marks_pop, clk, rst, take |=> (out_last == $past(pop)), "end-of-run flag out of step with pop")
  `ASSERT_RST(a_slot_in_run, clk, rst, stat.not_empty |-> (slot <= head.last_slot), "slot ran past the end of the run")

endmodule

// ===== src/slip_frame_encoder_top.sv =====
// A byte passes through a queue entry and then the output register after its item is
// accepted. Throughput: one line byte per cycle while out_ch is not stalled, bounded by
// the output register; an item expands to 1 to 4 line bytes (0 for a bare empty packet).
// Items enter one per cycle while the run queue has room.
// Reset (rst, synchronous) empties the queue and clears the output valid and byte slot.
// depends on sfe_pkg, sfe_in_if, sfe_out_if, sfe_front, sfe_queue, sfe_back
module slip_frame_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  sfe_in_if.sink    in_ch,
  sfe_out_if.source out_ch
);
  import sfe_pkg::*;

  logic    push;
  logic    pop;
  run_t    wr_run;
  run_t    head;
  q_stat_t stat;

  // classify and expand incoming items
  sfe_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .stat  (stat),
    .push  (push),
    .run   (wr_run)
  );

  // decouple front from back
  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_run (wr_run),
    .pop    (pop),
    .head   (head),
    .stat   (stat)
  );

  // serialize runs onto the line
  sfe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
